>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the run-code packer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/acrp_pkg.sv
// ---------------------------------------------------------------------------
// ASCII run-code packer package
// Byte classes, result kinds, code constants and the packer control structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package acrp_pkg;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_DIGIT = 2'd1,
    CLS_CAP   = 2'd2,
    CLS_LOWER = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_BADBYTE = 2'd2,
    KIND_TOOBIG  = 2'd3
  } kind_t;

  localparam int unsigned RUN_DEPTH = 16;
  localparam int unsigned RUN_AW    = 4;

  localparam logic [4:0] PFX_CAP       = 5'h00;
  localparam logic [4:0] PFX_DIGIT     = 5'h10;
  localparam logic [4:0] PFX_LOWER     = 5'h18;
  localparam logic [4:0] CODE_NEWLINE  = 5'h1F;
  localparam logic [4:0] RUN_MAX_CAP   = 5'd16;
  localparam logic [4:0] RUN_MAX_OTHER = 5'd8;

  localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
  localparam logic [7:0] DIGIT_LO     = 8'h20;
  localparam logic [7:0] DIGIT_HI     = 8'h3F;
  localparam logic [7:0] CAP_LO       = 8'h40;
  localparam logic [7:0] CAP_HI       = 8'h5F;
  localparam logic [7:0] LOWER_LO     = 8'h60;
  localparam logic [7:0] LOWER_END    = 8'h7F;

  // Command to the bit-serial packer
  typedef struct packed {
    logic       clear;
    logic       take;
    logic       load;
    logic [4:0] code;
  } pk_cmd_t;

  // Status from the bit-serial packer
  typedef struct packed {
    logic        busy;
    logic        full;
    logic        has_bits;
    logic        room;
    logic [7:0]  part;
    logic [31:0] done_cnt;
  } pk_stat_t;

  function automatic cls_t classify(input logic [7:0] b);
    cls_t c;
    c = CLS_NONE;
    if (b == BYTE_NEWLINE || (b >= LOWER_LO && b < LOWER_END)) begin
      c = CLS_LOWER;
    end else if (b >= DIGIT_LO && b <= DIGIT_HI) begin
      c = CLS_DIGIT;
    end else if (b >= CAP_LO && b <= CAP_HI) begin
      c = CLS_CAP;
    end
    return c;
  endfunction

  // Every class base is a multiple of 32, so the code is the low five bits.
  function automatic logic [4:0] code_of(input logic [7:0] b);
    logic [4:0] c;
    c = b[4:0];
    if (b == BYTE_NEWLINE) begin
      c = CODE_NEWLINE;
    end
    return c;
  endfunction

  function automatic logic [4:0] ctrl_code(input cls_t c, input logic [4:0] cnt);
    logic [4:0] pfx;
    case (c)
      CLS_CAP:   pfx = PFX_CAP;
      CLS_DIGIT: pfx = PFX_DIGIT;
      default:   pfx = PFX_LOWER;
    endcase
    return pfx | (cnt - 5'd1);
  endfunction

endpackage

>>> rtl/ascii_run_code_packer.sv
// ---------------------------------------------------------------------------
// ASCII run-code packer
// Groups text bytes into same-class runs and packs five-bit run codes LSB
// first into output bytes.
//
// Input channel (in_valid/in_ready) takes one byte per transaction; mark the
// last byte of a buffer with in_last_byte. Results leave on the out_ channel,
// one per transaction, the last of each input flagged by out_end_of_burst.
// The budget register sits at byte address 0 of the cfg_ APB port.
// Flow: a byte that closes no run and ends no buffer gives no result; a
// failing byte gives its failure result. Each five-bit code is loaded into
// the packer and then shifted in bit by bit, and closing a run sends its
// control code and then each stored code; the end of a buffer adds the
// partial flush and the done result. A new byte is taken only once the
// previous one is fully handled, since in_ready is high only at idle.
// Reset (rst_n, synchronous) clears the run, the partial byte, the byte
// count and the failed flag, and sets the budget to all ones. No clearing
// pass is needed. When the receiver stalls, one result waits in the output
// register and one in a staging register, then the packer holds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ascii_run_code_packer import acrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_out_byte,
  output logic [31:0] out_total_bytes,
  output logic        out_end_of_burst,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLASS, S_STORE, S_LAST, S_FLUSH, S_SHIFT,
    S_PARTIAL, S_DONE, S_FAIL, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_PRE, PH_MAX, PH_END
  } phase_t;

  state_t      state_r,   state_nxt;
  phase_t      ph_r,      ph_nxt;
  logic [7:0]  byte_r,    byte_nxt;
  logic        last_r,    last_nxt;
  logic [31:0] budget_r,  budget_nxt;
  logic        failed_r,  failed_nxt;
  cls_t        run_cls_r, run_cls_nxt;
  logic [4:0]  run_cnt_r, run_cnt_nxt;
  logic [4:0]  codes_r,   codes_nxt;
  logic [RUN_AW-1:0] idx_r, idx_nxt;
  kind_t       fkind_r,   fkind_nxt;

  logic        stg_v_r,     stg_v_nxt;
  kind_t       stg_kind_r,  stg_kind_nxt;
  logic [7:0]  stg_byte_r,  stg_byte_nxt;
  logic [31:0] stg_total_r, stg_total_nxt;

  logic        out_v_r,     out_v_nxt;
  kind_t       out_kind_r,  out_kind_nxt;
  logic [7:0]  out_byte_r,  out_byte_nxt;
  logic [31:0] out_total_r, out_total_nxt;
  logic        out_eob_r,   out_eob_nxt;

  pk_cmd_t     pk_cmd;
  pk_stat_t    pk_stat;
  logic        wr_en;
  logic [4:0]  rd_data;

  cls_t        cls;
  logic [4:0]  max_len;
  logic        can_push;
  logic        slot_ok;
  logic        emit_go;
  kind_t       emit_kind;
  logic [7:0]  emit_byte;
  logic [31:0] emit_total;
  logic        push_last;
  logic        clear_all;
  logic        cfg_wr;
  state_t      ret_state;

  acrp_run_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (run_cnt_r[RUN_AW-1:0]),
    .wr_data (code_of(byte_r)),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  acrp_bit_packer u_packer (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (pk_cmd),
    .budget (budget_r),
    .stat   (pk_stat)
  );

  assign cls      = classify(byte_r);
  assign max_len  = (cls == CLS_CAP) ? RUN_MAX_CAP : RUN_MAX_OTHER;
  assign can_push = !out_v_r || out_ready;
  assign slot_ok  = !stg_v_r || can_push;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    case (ph_r)
      PH_PRE:  ret_state = S_STORE;
      PH_MAX:  ret_state = S_LAST;
      default: ret_state = S_PARTIAL;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    ph_nxt      = ph_r;
    byte_nxt    = byte_r;
    last_nxt    = last_r;
    budget_nxt  = budget_r;
    failed_nxt  = failed_r;
    run_cls_nxt = run_cls_r;
    run_cnt_nxt = run_cnt_r;
    codes_nxt   = codes_r;
    idx_nxt     = idx_r;
    fkind_nxt   = fkind_r;
    pk_cmd      = '0;
    wr_en       = 1'b0;
    emit_go     = 1'b0;
    emit_kind   = KIND_BYTE;
    emit_byte   = 8'd0;
    emit_total  = pk_stat.done_cnt;
    push_last   = 1'b0;
    clear_all   = 1'b0;

    if (cfg_wr && !cfg_paddr[2]) begin
      budget_nxt = cfg_pwdata;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt  = in_data_byte;
          last_nxt  = in_last_byte;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        if (failed_r) begin
          // swallow the byte; the last byte of a buffer rearms the block
          clear_all = last_r;
          state_nxt = S_IDLE;
        end else if (budget_r == 32'd0) begin
          fkind_nxt = KIND_TOOBIG;
          state_nxt = S_FAIL;
        end else if (cls == CLS_NONE) begin
          fkind_nxt = KIND_BADBYTE;
          state_nxt = S_FAIL;
        end else if (run_cnt_r != 5'd0 && cls != run_cls_r) begin
          ph_nxt    = PH_PRE;
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        wr_en       = 1'b1;
        run_cnt_nxt = run_cnt_r + 5'd1;
        if (run_cnt_r == 5'd0) begin
          run_cls_nxt = cls;
        end
        if (run_cnt_r + 5'd1 == max_len) begin
          ph_nxt    = PH_MAX;
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        if (last_r) begin
          ph_nxt    = PH_END;
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FLUSH: begin
        if (run_cnt_r == 5'd0) begin
          state_nxt = ret_state;
        end else begin
          pk_cmd.load = 1'b1;
          pk_cmd.code = ctrl_code(run_cls_r, run_cnt_r);
          codes_nxt   = run_cnt_r;
          idx_nxt     = '0;
          run_cnt_nxt = 5'd0;
          state_nxt   = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (pk_stat.full) begin
          if (!pk_stat.room) begin
            fkind_nxt = KIND_TOOBIG;
            state_nxt = S_FAIL;
          end else if (slot_ok) begin
            emit_go     = 1'b1;
            emit_byte   = pk_stat.part;
            emit_total  = pk_stat.done_cnt + 32'd1;
            pk_cmd.take = 1'b1;
          end
        end else if (!pk_stat.busy) begin
          if (codes_r != 5'd0) begin
            pk_cmd.load = 1'b1;
            pk_cmd.code = rd_data;
            codes_nxt   = codes_r - 5'd1;
            idx_nxt     = idx_r + RUN_AW'(1);
          end else begin
            state_nxt = ret_state;
          end
        end
      end
      S_PARTIAL: begin
        if (!pk_stat.has_bits) begin
          state_nxt = S_DONE;
        end else if (!pk_stat.room) begin
          fkind_nxt = KIND_TOOBIG;
          state_nxt = S_FAIL;
        end else if (slot_ok) begin
          emit_go     = 1'b1;
          emit_byte   = pk_stat.part;
          emit_total  = pk_stat.done_cnt + 32'd1;
          pk_cmd.take = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_ok) begin
          emit_go   = 1'b1;
          emit_kind = KIND_DONE;
          clear_all = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FAIL: begin
        if (slot_ok) begin
          emit_go    = 1'b1;
          emit_kind  = fkind_r;
          failed_nxt = 1'b1;
          clear_all  = last_r;
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        // release the held result as the end of this input's burst
        if (!stg_v_r) begin
          state_nxt = S_IDLE;
        end else if (can_push) begin
          push_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (clear_all) begin
      pk_cmd.clear = 1'b1;
      run_cnt_nxt  = 5'd0;
      run_cls_nxt  = CLS_NONE;
      failed_nxt   = 1'b0;
    end
  end

  // Staging and output registers: hold one result back until the next one
  // shows whether it ends the burst.
  always_comb begin
    stg_v_nxt     = stg_v_r;
    stg_kind_nxt  = stg_kind_r;
    stg_byte_nxt  = stg_byte_r;
    stg_total_nxt = stg_total_r;
    out_v_nxt     = out_v_r;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_total_nxt = out_total_r;
    out_eob_nxt   = out_eob_r;
    if (out_v_r && out_ready) begin
      out_v_nxt = 1'b0;
    end
    if ((emit_go && stg_v_r) || push_last) begin
      out_v_nxt     = 1'b1;
      out_kind_nxt  = stg_kind_r;
      out_byte_nxt  = stg_byte_r;
      out_total_nxt = stg_total_r;
      out_eob_nxt   = push_last;
    end
    if (push_last) begin
      stg_v_nxt = 1'b0;
    end
    if (emit_go) begin
      stg_v_nxt     = 1'b1;
      stg_kind_nxt  = emit_kind;
      stg_byte_nxt  = emit_byte;
      stg_total_nxt = emit_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ph_r      <= PH_PRE;
      budget_r  <= 32'hFFFF_FFFF;
      failed_r  <= 1'b0;
      run_cls_r <= CLS_NONE;
      run_cnt_r <= 5'd0;
      codes_r   <= 5'd0;
      idx_r     <= '0;
      stg_v_r   <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ph_r      <= ph_nxt;
      budget_r  <= budget_nxt;
      failed_r  <= failed_nxt;
      run_cls_r <= run_cls_nxt;
      run_cnt_r <= run_cnt_nxt;
      codes_r   <= codes_nxt;
      idx_r     <= idx_nxt;
      stg_v_r   <= stg_v_nxt;
      out_v_r   <= out_v_nxt;
    end
    byte_r      <= byte_nxt;
    last_r      <= last_nxt;
    fkind_r     <= fkind_nxt;
    stg_kind_r  <= stg_kind_nxt;
    stg_byte_r  <= stg_byte_nxt;
    stg_total_r <= stg_total_nxt;
    out_kind_r  <= out_kind_nxt;
    out_byte_r  <= out_byte_nxt;
    out_total_r <= out_total_nxt;
    out_eob_r   <= out_eob_nxt;
  end

  assign out_valid        = out_v_r;
  assign out_kind         = out_kind_r;
  assign out_out_byte     = out_byte_r;
  assign out_total_bytes  = out_total_r;
  assign out_end_of_burst = out_eob_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : budget_r;

  `ASSERT_IMPL(a_idle_stage_empty, clk, rst_n, in_ready, !stg_v_r, "result left staged at idle")
  `ASSERT_IMPL(a_load_when_free, clk, rst_n, pk_cmd.load, !pk_stat.busy && !pk_stat.full, "code loaded while packer busy")
  `ASSERT_IMPL(a_final_kind_ends, clk, rst_n, out_v_r && out_kind_r != KIND_BYTE, out_eob_r, "status result not at end of burst")
  `ASSERT_IMPL(a_run_bound, clk, rst_n, 1'b1, run_cnt_r <= RUN_MAX_CAP, "run count beyond limit")
  `ASSERT_NEXT(a_fail_sets_flag, clk, rst_n, state_r == S_FAIL && slot_ok && !last_r, failed_r, "failure not recorded")

endmodule

>>> rtl/acrp_run_store.sv
// ---------------------------------------------------------------------------
// Run store
// Holds the five-bit codes of the open run; one write and one registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module acrp_run_store import acrp_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [RUN_AW-1:0] wr_addr,
  input  logic [4:0]        wr_data,
  input  logic [RUN_AW-1:0] rd_addr,
  output logic [4:0]        rd_data
);

  logic [4:0] mem_r [RUN_DEPTH];
  logic [4:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/acrp_bit_packer.sv
// ---------------------------------------------------------------------------
// Bit-serial packer
// Shifts one code bit per cycle into the partial byte, LSB first, while no
// finished byte waits, and counts the bytes taken against the budget.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module acrp_bit_packer import acrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pk_cmd_t     cmd,
  input  logic [31:0] budget,
  output pk_stat_t    stat
);

  logic [4:0]  sh_r,    sh_nxt;
  logic [2:0]  left_r,  left_nxt;
  logic [7:0]  part_r,  part_nxt;
  logic [3:0]  pbits_r, pbits_nxt;
  logic [31:0] done_r,  done_nxt;
  logic        full;

  assign full = (pbits_r == 4'd8);

  always_comb begin
    sh_nxt    = sh_r;
    left_nxt  = left_r;
    part_nxt  = part_r;
    pbits_nxt = pbits_r;
    done_nxt  = done_r;
    if (cmd.clear) begin
      left_nxt  = 3'd0;
      part_nxt  = 8'd0;
      pbits_nxt = 4'd0;
      done_nxt  = 32'd0;
    end else if (cmd.take) begin
      part_nxt  = 8'd0;
      pbits_nxt = 4'd0;
      done_nxt  = done_r + 32'd1;
    end else if (cmd.load) begin
      sh_nxt   = cmd.code;
      left_nxt = 3'd5;
    end else if (left_r != 3'd0 && !full) begin
      // advance one bit; stall while a finished byte waits
      part_nxt[pbits_r[2:0]] = sh_r[0];
      sh_nxt    = {1'b0, sh_r[4:1]};
      left_nxt  = left_r - 3'd1;
      pbits_nxt = pbits_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= 3'd0;
      part_r  <= 8'd0;
      pbits_r <= 4'd0;
      done_r  <= 32'd0;
    end else begin
      left_r  <= left_nxt;
      part_r  <= part_nxt;
      pbits_r <= pbits_nxt;
      done_r  <= done_nxt;
    end
    sh_r <= sh_nxt;
  end

  always_comb begin
    stat.busy     = (left_r != 3'd0);
    stat.full     = full;
    stat.has_bits = (pbits_r != 4'd0);
    stat.room     = (({1'b0, done_r} + 33'd1) < {1'b0, budget});
    stat.part     = part_r;
    stat.done_cnt = done_r;
  end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// ASCII run-code packer testbench
// Sends text buffers through the packer in random bursts while the result side
// stalls on shifting ready patterns. An in-bench model of the run grouping and
// LSB-first code packing predicts every result, which is checked field by
// field in order. The output budget is swept through its extremes between
// phases, each phase ending on a buffer boundary.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import acrp_pkg::*; ();

  localparam logic [2:0] REG_OUTPUT_BUDGET = 3'd0;
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } text_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value;
    logic [31:0] total;
    logic        eob;
  } packer_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_out_byte;
  logic [31:0] out_total_bytes;
  logic        out_end_of_burst;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ascii_run_code_packer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_out_byte     (out_out_byte),
    .out_total_bytes  (out_total_bytes),
    .out_end_of_burst (out_end_of_burst),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Packer model state
  logic [31:0] budget = 32'hFFFF_FFFF;
  logic [4:0]  run_sym [16];
  cls_t        run_kind = CLS_NONE;
  logic [4:0]  run_len = 5'd0;
  logic [7:0]  acc_bits = 8'h00;
  logic [3:0]  acc_fill = 4'd0;
  logic [31:0] emitted_cnt = 32'd0;
  logic        halted = 1'b0;

  text_item_t     pending_q [$];
  packer_result_t burst_q [$];
  packer_result_t expected_q [$];

  int err_cnt = 0;
  int cycle_cnt = 0;

  function automatic cls_t byte_class(input logic [7:0] b);
    if (b == 8'h0A || (b >= 8'h60 && b <= 8'h7E)) return CLS_LOWER;
    if (b >= 8'h20 && b <= 8'h3F) return CLS_DIGIT;
    if (b >= 8'h40 && b <= 8'h5F) return CLS_CAP;
    return CLS_NONE;
  endfunction

  function automatic void note_result(input kind_t k, input logic [7:0] v);
    packer_result_t r;
    r.kind  = k;
    r.value = v;
    r.total = emitted_cnt;
    r.eob   = 1'b0;
    burst_q.push_back(r);
  endfunction

  function automatic void clear_text_state();
    run_kind    = CLS_NONE;
    run_len     = 5'd0;
    acc_bits    = 8'h00;
    acc_fill    = 4'd0;
    emitted_cnt = 32'd0;
    halted      = 1'b0;
  endfunction

  function automatic bit fits_one_more();
    return ({1'b0, emitted_cnt} + 33'd1) < {1'b0, budget};
  endfunction

  // Shift one code in LSB first; a completed byte past the budget fails.
  function automatic bit shift_code(input logic [4:0] code);
    for (int i = 0; i < 5; i++) begin
      acc_bits[acc_fill[2:0]] = code[i];
      acc_fill++;
      if (acc_fill == 4'd8) begin
        if (!fits_one_more()) return 1'b0;
        emitted_cnt++;
        note_result(KIND_BYTE, acc_bits);
        acc_bits = 8'h00;
        acc_fill = 4'd0;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit close_run();
    logic [4:0] pfx;
    int n;
    n = run_len;
    run_len = 5'd0;
    if (n == 0) return 1'b1;
    case (run_kind)
      CLS_CAP:   pfx = PFX_CAP;
      CLS_DIGIT: pfx = PFX_DIGIT;
      default:   pfx = PFX_LOWER;
    endcase
    if (!shift_code(pfx | 5'(n - 1))) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!shift_code(run_sym[i])) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void enter_failure(input kind_t k, input logic fin);
    note_result(k, 8'h00);
    halted = 1'b1;
    if (fin) clear_text_state();
  endfunction

  task automatic predict_packing(input logic [7:0] b, input logic fin);
    cls_t c;
    int lim;
    bit ok;
    burst_q.delete();
    c = byte_class(b);
    if (halted) begin
      // swallow silently until the buffer ends
      if (fin) clear_text_state();
    end else if (budget == 32'd0) begin
      enter_failure(KIND_TOOBIG, fin);
    end else if (c == CLS_NONE) begin
      enter_failure(KIND_BADBYTE, fin);
    end else begin
      ok = 1'b1;
      if (run_len > 0 && c != run_kind) ok = close_run();
      if (ok) begin
        if (run_len == 0) run_kind = c;
        run_sym[run_len[3:0]] = (b == 8'h0A) ? 5'h1F : b[4:0];
        run_len++;
        lim = (c == CLS_CAP) ? 16 : 8;
        if (run_len >= lim) ok = close_run();
      end
      if (ok && fin) begin
        ok = close_run();
        if (ok && acc_fill != 4'd0) begin
          if (!fits_one_more()) begin
            ok = 1'b0;
          end else begin
            emitted_cnt++;
            note_result(KIND_BYTE, acc_bits);
          end
        end
        if (ok) begin
          note_result(KIND_DONE, 8'h00);
          clear_text_state();
        end
      end
      if (!ok) enter_failure(KIND_TOOBIG, fin);
    end
    if (burst_q.size() > 0) begin
      burst_q[burst_q.size() - 1].eob = 1'b1;
      foreach (burst_q[i]) expected_q.push_back(burst_q[i]);
    end
  endtask

  // Sender: random bursts separated by random gaps
  int burst_left = 1;
  int gap_left = 0;
  text_item_t next_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_packing(in_data_byte, in_last_byte);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          next_item = pending_q.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= next_item.data;
          in_last_byte <= next_item.fin;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready follows a 16-bit pattern, redrawn every pass
  logic [15:0] ready_pat = 16'hFFFF;
  int pat_pos = 0;
  packer_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt < 50)
            $display("%0t: unexpected transaction kind=%0d byte=%02h total=%0d eob=%0b",
                     $time, out_kind, out_out_byte, out_total_bytes, out_end_of_burst);
        end else begin
          want = expected_q.pop_front();
          if (out_kind !== want.kind || out_out_byte !== want.value ||
              out_total_bytes !== want.total || out_end_of_burst !== want.eob) begin
            err_cnt++;
            if (err_cnt < 50)
              $display("%0t: mismatch expected kind=%0d byte=%02h total=%0d eob=%0b, %s",
                       $time, want.kind, want.value, want.total, want.eob,
                       $sformatf("actual kind=%0d byte=%02h total=%0d eob=%0b",
                                 out_kind, out_out_byte, out_total_bytes,
                                 out_end_of_burst));
          end
        end
      end
      out_ready <= ready_pat[pat_pos];
      if (pat_pos == 15) begin
        pat_pos = 0;
        case ($urandom_range(0, 3))
          0:       ready_pat = 16'hFFFF;
          1:       ready_pat = 16'($urandom);
          2:       ready_pat = ~(16'($urandom) & 16'($urandom));
          default: ready_pat = 16'($urandom) & 16'($urandom) | 16'h0001;
        endcase
      end else begin
        pat_pos++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void add_item(input logic [7:0] b, input logic fin);
    text_item_t it;
    it.data = b;
    it.fin  = fin;
    pending_q.push_back(it);
  endfunction

  function automatic logic [7:0] text_byte(input cls_t c);
    case (c)
      CLS_DIGIT: return 8'h20 + 8'($urandom_range(0, 31));
      CLS_CAP:   return 8'h40 + 8'($urandom_range(0, 31));
      CLS_LOWER: return ($urandom_range(0, 7) == 0) ? 8'h0A : 8'h60 + 8'($urandom_range(0, 30));
      default: begin
        case ($urandom_range(0, 2))
          0:       return 8'($urandom_range(8'h00, 8'h09));
          1:       return 8'($urandom_range(8'h0B, 8'h1F));
          default: return 8'($urandom_range(8'h7F, 8'hFF));
        endcase
      end
    endcase
  endfunction

  // Well-formed buffers of same-class runs, with the odd unsupported byte
  task automatic queue_random_text(input int n_items);
    int made, blen, rlen, lim;
    cls_t c;
    made = 0;
    while (made < n_items) begin
      blen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
      // trim the final buffer so the phase stops at its item count
      if (blen > n_items - made) blen = n_items - made;
      while (blen > 0) begin
        c = cls_t'($urandom_range(1, 3));
        lim = (c == CLS_CAP) ? 16 : 8;
        rlen = ($urandom_range(0, 2) == 0) ? lim : $urandom_range(1, lim + 3);
        for (int k = 0; k < rlen && blen > 0; k++) begin
          add_item(($urandom_range(0, 29) == 0) ? text_byte(CLS_NONE) : text_byte(c),
                   blen == 1);
          blen--;
          made++;
        end
      end
    end
  endtask

  task automatic write_budget(input logic [31:0] v);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_OUTPUT_BUDGET;
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    budget = v;
  endtask

  // Hold until every transaction is in and answered, then let the packer settle
  task automatic drain();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    write_budget(32'hFFFF_FFFF);
    // one run per class at its range edges, newline closing the buffer
    add_item(8'h40, 1'b0);
    add_item(8'h5F, 1'b0);
    add_item(8'h20, 1'b0);
    add_item(8'h3F, 1'b0);
    add_item(8'h60, 1'b0);
    add_item(8'h7E, 1'b0);
    add_item(8'h0A, 1'b1);
    // unsupported byte mid-buffer, then silent bytes until the end
    add_item(8'h41, 1'b0);
    add_item(8'h00, 1'b0);
    add_item(8'h42, 1'b0);
    add_item(8'h43, 1'b1);
    // failing bytes that also end the buffer, then a valid one-byte buffer
    add_item(8'h7F, 1'b1);
    add_item(8'hFF, 1'b1);
    add_item(8'h61, 1'b1);
    queue_random_text(55);
    drain();

    write_budget(32'd0);
    add_item(8'h41, 1'b0);
    add_item(8'h42, 1'b1);
    add_item(8'h00, 1'b1);
    queue_random_text(10);
    drain();

    // first completed byte already hits the budget
    write_budget(32'd1);
    add_item(8'h41, 1'b0);
    add_item(8'h42, 1'b0);
    add_item(8'h43, 1'b1);
    drain();

    // too big on the final partial flush
    write_budget(32'd2);
    add_item(8'h61, 1'b1);
    drain();

    write_budget(32'($urandom_range(3, 24)));
    queue_random_text(55);
    drain();

    write_budget(32'($urandom_range(25, 60)));
    queue_random_text(50);
    drain();

    write_budget(32'hFFFF_FFFF);
    queue_random_text(55);
    drain();

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> ascii_run_code_packer.f
+incdir+rtl
rtl/acrp_pkg.sv
rtl/acrp_run_store.sv
rtl/acrp_bit_packer.sv
rtl/ascii_run_code_packer.sv
test/tb_top.sv
